// File: rtl/bto_pkg.sv
// shared types, constants and helpers of the binomial tree option pricer
package bto_pkg;

    localparam int MAX_NODES    = 1024;
    localparam int ADDR_W       = $clog2(MAX_NODES);
    localparam int WORD_W       = 32;
    localparam int DOWN_W       = 31;
    localparam int STEPS_W      = 10;
    localparam int CFG_INDEX_W  = 3;
    localparam int DRAIN_CYCLES = 4;
    localparam int DRN_W        = $clog2(DRAIN_CYCLES);

    localparam logic [WORD_W-1:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [WORD_W-1:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DOWN_FACTOR   = 3'd0,
        REG_UP_DOWN_RATIO = 3'd1,
        REG_UP_PROB       = 3'd2,
        REG_STEP_DISCOUNT = 3'd3,
        REG_TREE_STEPS    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOWN,
        ST_LEAF,
        ST_ROW,
        ST_DRAIN,
        ST_FINAL_RD,
        ST_FINAL_LD
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] spot_price;
        logic [WORD_W-1:0] strike_price;
        logic              is_put;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] option_price;
        logic              overflow;
    } out_word_t;

    typedef struct packed {
        logic              load_item;
        logic              down_step;
        logic              leaf_write;
        logic              leaf_up;
        logic              rd_en;
        logic              rd_pair;
        logic              out_load;
        logic [ADDR_W-1:0] addr;
    } dp_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] n_steps;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] clamp_steps(input logic [STEPS_W-1:0] steps);
        logic [ADDR_W-1:0] res;
        if (32'(steps) > 32'(MAX_NODES - 1)) begin
            res = ADDR_W'(MAX_NODES - 1);
        end else begin
            res = ADDR_W'(steps);
        end
        return res;
    endfunction

endpackage

// File: rtl/binomial_tree_option_pricer_unit.sv
// top level of the binomial tree option pricer
//
//   port group        direction  carries
//   s_valid/s_ready   in         one word: spot, strike, put select
//   m_valid/m_ready   out        one word: root price, overflow flag
//   cfg_wr_en         in         register write, index and data
//
// the time one word takes for N tree steps is set by the single read port of the
// node memory and the node update pipeline that drains between rows
// reset clears control, config and the overflow flag only; node memory has no clearing pass
// a finished result waits in the output register while the next word is taken;
// that word then holds before its final read until the register is free
module binomial_tree_option_pricer_unit import bto_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_word
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bto_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bto_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_word      (s_word),
        .cmd         (cmd),
        .status      (status),
        .m_word      (m_word)
    );

endmodule

// File: rtl/bto_ram.sv
// generic single-write, single-read ram with registered read data
module bto_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bto_datapath.sv
// config registers, leaf multiplier, node update pipeline and node memory
module bto_datapath import bto_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_wr_data,
    input  in_word_t               s_word,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output out_word_t              m_word
);

    logic [DOWN_W-1:0]  down_factor_reg;
    logic [WORD_W-1:0]  ratio_reg;
    logic [WORD_W-1:0]  up_prob_reg;
    logic [WORD_W-1:0]  discount_reg;
    logic [STEPS_W-1:0] steps_reg;

    logic [WORD_W-1:0]  p_sat;
    logic [WORD_W-1:0]  q_sat;
    logic [WORD_W-1:0]  disc_sat;

    logic [WORD_W-1:0]  leaf_reg;
    logic [WORD_W-1:0]  strike_reg;
    logic               put_reg;
    logic               sat_reg;

    logic [WORD_W-1:0]   factor;
    logic [2*WORD_W-1:0] leaf_prod;
    logic [WORD_W+1:0]   leaf_shift;
    logic [WORD_W-1:0]   leaf_next;
    logic                leaf_ovf;
    logic [WORD_W-1:0]   payoff;

    logic                s1_rdv_reg;
    logic                s1_pair_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [WORD_W-1:0]   prev_reg;
    logic                s2_valid_reg;
    logic [ADDR_W-1:0]   s2_addr_reg;
    logic [2*WORD_W-1:0] prod_p_reg;
    logic [2*WORD_W-1:0] prod_q_reg;
    logic                s3_valid_reg;
    logic [ADDR_W-1:0]   s3_addr_reg;
    logic [WORD_W-1:0]   w_reg;
    logic                s4_valid_reg;
    logic [ADDR_W-1:0]   s4_addr_reg;
    logic [2*WORD_W-1:0] dprod_reg;
    logic [2*WORD_W-1:0] mix_sum;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic [WORD_W-1:0]   ram_rd_data;

    logic [WORD_W-1:0]   price_reg;
    logic                overflow_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_factor_reg <= ONE_Q30[DOWN_W-1:0];
            ratio_reg       <= ONE_Q30;
            up_prob_reg     <= ONE_Q30;
            discount_reg    <= ONE_Q31;
            steps_reg       <= STEPS_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DOWN_FACTOR:   down_factor_reg <= cfg_wr_data[DOWN_W-1:0];
                REG_UP_DOWN_RATIO: ratio_reg       <= cfg_wr_data;
                REG_UP_PROB:       up_prob_reg     <= cfg_wr_data;
                REG_STEP_DISCOUNT: discount_reg    <= cfg_wr_data;
                REG_TREE_STEPS:    steps_reg       <= cfg_wr_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign p_sat    = (up_prob_reg > ONE_Q31) ? ONE_Q31 : up_prob_reg;
    assign q_sat    = ONE_Q31 - p_sat;
    assign disc_sat = (discount_reg > ONE_Q31) ? ONE_Q31 : discount_reg;

    assign status.n_steps = clamp_steps(steps_reg);

    // leaf generation
    assign factor     = cmd.down_step ? {1'b0, down_factor_reg} : ratio_reg;
    assign leaf_prod  = {{WORD_W{1'b0}}, leaf_reg} * {{WORD_W{1'b0}}, factor};
    assign leaf_shift = leaf_prod[2*WORD_W-1:30];
    assign leaf_ovf   = (leaf_shift[WORD_W+1:WORD_W] != 2'b00);
    assign leaf_next  = leaf_ovf ? {WORD_W{1'b1}} : leaf_shift[WORD_W-1:0];

    always_comb begin
        if (put_reg) begin
            payoff = (strike_reg > leaf_reg) ? strike_reg - leaf_reg : '0;
        end else begin
            payoff = (leaf_reg > strike_reg) ? leaf_reg - strike_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
        end else if (cmd.load_item) begin
            sat_reg <= 1'b0;
        end else if ((cmd.down_step || cmd.leaf_up) && leaf_ovf) begin
            sat_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            leaf_reg   <= s_word.spot_price;
            strike_reg <= s_word.strike_price;
            put_reg    <= s_word.is_put;
        end else if (cmd.down_step || cmd.leaf_up) begin
            leaf_reg <= leaf_next;
        end
    end

    // node update pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_rdv_reg   <= 1'b0;
            s1_pair_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_rdv_reg   <= cmd.rd_en;
            s1_pair_reg  <= cmd.rd_en && cmd.rd_pair;
            s2_valid_reg <= s1_pair_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign mix_sum = prod_p_reg + prod_q_reg;

    always_ff @(posedge aclk) begin
        s1_addr_reg <= cmd.addr - 1'b1;
        if (s1_rdv_reg) begin
            prev_reg <= ram_rd_data;
        end
        s2_addr_reg <= s1_addr_reg;
        prod_p_reg  <= {{WORD_W{1'b0}}, p_sat} * {{WORD_W{1'b0}}, ram_rd_data};
        prod_q_reg  <= {{WORD_W{1'b0}}, q_sat} * {{WORD_W{1'b0}}, prev_reg};
        s3_addr_reg <= s2_addr_reg;
        w_reg       <= mix_sum[2*WORD_W-2:WORD_W-1];
        s4_addr_reg <= s3_addr_reg;
        dprod_reg   <= {{WORD_W{1'b0}}, disc_sat} * {{WORD_W{1'b0}}, w_reg};
    end

    // node memory write port
    always_comb begin
        ram_wr_en   = s4_valid_reg || cmd.leaf_write;
        ram_wr_addr = cmd.addr;
        ram_wr_data = payoff;
        if (s4_valid_reg) begin
            ram_wr_addr = s4_addr_reg;
            ram_wr_data = dprod_reg[2*WORD_W-2:WORD_W-1];
        end
    end

    bto_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.addr),
        .rd_data (ram_rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            price_reg    <= ram_rd_data;
            overflow_reg <= sat_reg;
        end
    end

    assign m_word.option_price = price_reg;
    assign m_word.overflow     = overflow_reg;

`ifndef NO_ASSERTIONS
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.leaf_write && s4_valid_reg))
        else $error("leaf write collides with node update write");

    a_no_stale_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && s4_valid_reg) |-> (cmd.addr != s4_addr_reg))
        else $error("node read hits a pending write");

    a_load_clears_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |=> !sat_reg)
        else $error("overflow flag not cleared for new word");
`endif

endmodule

// File: rtl/bto_ctrl.sv
// sequencer for leaf generation, backward induction rows and result handoff
module bto_ctrl import bto_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [DRN_W-1:0]  drn_reg, drn_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            j_reg       <= '0;
            drn_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            j_reg       <= j_next;
            drn_reg     <= drn_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        j_next       = j_reg;
        drn_next     = drn_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_next   = '0;
                    state_next = (status.n_steps == '0) ? ST_LEAF : ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (cnt_reg == status.n_steps - 1'b1) begin
                    cnt_next   = '0;
                    state_next = ST_LEAF;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LEAF: begin
                if (cnt_reg == status.n_steps) begin
                    cnt_next   = '0;
                    j_next     = status.n_steps;
                    state_next = (status.n_steps == '0) ? ST_FINAL_RD : ST_ROW;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROW: begin
                if (cnt_reg == j_reg) begin
                    drn_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (drn_reg == DRN_W'(DRAIN_CYCLES - 1)) begin
                    cnt_next   = '0;
                    j_next     = j_reg - 1'b1;
                    state_next = (j_reg == ADDR_W'(1)) ? ST_FINAL_RD : ST_ROW;
                end else begin
                    drn_next = drn_reg + 1'b1;
                end
            end
            ST_FINAL_RD: begin
                if (out_free) begin
                    state_next = ST_FINAL_LD;
                end
            end
            ST_FINAL_LD: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_DOWN: begin
                cmd.down_step = 1'b1;
            end
            ST_LEAF: begin
                cmd.leaf_write = 1'b1;
                cmd.leaf_up    = (cnt_reg != status.n_steps);
                cmd.addr       = cnt_reg;
            end
            ST_ROW: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_pair = (cnt_reg != '0);
                cmd.addr    = cnt_reg;
            end
            ST_DRAIN: ;
            ST_FINAL_RD: begin
                cmd.rd_en = out_free;
            end
            ST_FINAL_LD: begin
                cmd.out_load = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg)
        else $error("result register overwritten before handoff");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) |-> (cnt_reg <= j_reg))
        else $error("row read address past row end");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINAL_LD))
        else $error("result raised outside final load");
`endif

endmodule

// File: sim/binomial_tree_option_pricer_unit_tb.sv
// testbench of the binomial tree option pricer: directed and random words against a tree model
module binomial_tree_option_pricer_unit_tb import bto_pkg::*; ();

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3_000_000;
    localparam int END_SLACK      = 8 * DRAIN_CYCLES;
    localparam int RANDOM_PHASES  = 8;

    localparam logic [WORD_W-1:0]  WORD_ALL_ONES = '1;
    localparam logic [DOWN_W-1:0]  DOWN_ALL_ONES = '1;
    localparam logic [STEPS_W-1:0] STEPS_MAX     = STEPS_W'(MAX_NODES - 1);
    localparam logic [WORD_W-1:0]  PRICE_100     = 32'h0064_0000;
    localparam logic [WORD_W-1:0]  PRICE_90      = 32'h005A_0000;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [WORD_W-1:0]      cfg_wr_data = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    in_word_t               s_word      = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    out_word_t              m_word;

    // model copy of the register file and the node store
    logic [DOWN_W-1:0]  model_down  = ONE_Q30[DOWN_W-1:0];
    logic [WORD_W-1:0]  model_ratio = ONE_Q30;
    logic [WORD_W-1:0]  model_prob  = ONE_Q30;
    logic [WORD_W-1:0]  model_disc  = ONE_Q31;
    logic [STEPS_W-1:0] model_steps = STEPS_W'(1);
    logic [WORD_W-1:0]  node_vals [MAX_NODES];

    out_word_t   expected_prices [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned ready_hold     = 0;
    bit          no_idle        = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    binomial_tree_option_pricer_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

    // top bit flags saturation
    function automatic logic [WORD_W:0] scale_leaf(input logic [WORD_W-1:0] price,
                                                   input logic [WORD_W-1:0] factor);
        logic [63:0] prod;
        prod = (64'(price) * 64'(factor)) >> 30;
        if (prod > 64'(WORD_ALL_ONES)) begin
            return {1'b1, WORD_ALL_ONES};
        end
        return {1'b0, prod[WORD_W-1:0]};
    endfunction

    function automatic logic [WORD_W-1:0] payoff_of(input logic [WORD_W-1:0] leaf,
                                                    input logic [WORD_W-1:0] strike,
                                                    input logic put);
        if (put) begin
            return (strike > leaf) ? strike - leaf : '0;
        end
        return (leaf > strike) ? leaf - strike : '0;
    endfunction

    function automatic out_word_t price_option(input in_word_t w);
        int                n;
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] q;
        logic [WORD_W-1:0] disc;
        logic [WORD_W-1:0] leaf;
        logic [WORD_W:0]   scaled;
        logic [63:0]       mix;
        bit                sat;
        out_word_t         res;
        n    = (int'(model_steps) > MAX_NODES - 1) ? MAX_NODES - 1 : int'(model_steps);
        p    = (model_prob > ONE_Q31) ? ONE_Q31 : model_prob;
        q    = ONE_Q31 - p;
        disc = (model_disc > ONE_Q31) ? ONE_Q31 : model_disc;
        sat  = 1'b0;
        leaf = w.spot_price;
        for (int i = 0; i < n; i++) begin
            scaled = scale_leaf(leaf, 32'(model_down));
            sat    = sat | scaled[WORD_W];
            leaf   = scaled[WORD_W-1:0];
        end
        for (int i = 0; i <= n; i++) begin
            if (i > 0) begin
                scaled = scale_leaf(leaf, model_ratio);
                sat    = sat | scaled[WORD_W];
                leaf   = scaled[WORD_W-1:0];
            end
            node_vals[i] = payoff_of(leaf, w.strike_price, w.is_put);
        end
        for (int j = n; j > 0; j--) begin
            for (int i = 0; i < j; i++) begin
                mix = (64'(p) * 64'(node_vals[i + 1]) + 64'(q) * 64'(node_vals[i])) >> 31;
                node_vals[i] = 32'((64'(disc) * mix) >> 31);
            end
        end
        res.option_price = node_vals[0];
        res.overflow     = sat;
        return res;
    endfunction

    function automatic in_word_t make_word(input logic [WORD_W-1:0] spot,
                                           input logic [WORD_W-1:0] strike,
                                           input logic put);
        in_word_t w;
        w.spot_price   = spot;
        w.strike_price = strike;
        w.is_put       = put;
        return w;
    endfunction

    function automatic int unsigned pick_gap();
        if (no_idle) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 200);
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic send_item(input in_word_t w);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        expected_prices.push_back(price_option(w));
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_prices.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (cfg_reg_t'(idx))
            REG_DOWN_FACTOR:   model_down  = data[DOWN_W-1:0];
            REG_UP_DOWN_RATIO: model_ratio = data;
            REG_UP_PROB:       model_prob  = data;
            REG_STEP_DISCOUNT: model_disc  = data;
            REG_TREE_STEPS:    model_steps = data[STEPS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_tree(input logic [WORD_W-1:0] down, input logic [WORD_W-1:0] ratio,
                            input logic [WORD_W-1:0] prob, input logic [WORD_W-1:0] disc,
                            input logic [WORD_W-1:0] steps);
        write_cfg(REG_DOWN_FACTOR, down);
        write_cfg(REG_UP_DOWN_RATIO, ratio);
        write_cfg(REG_UP_PROB, prob);
        write_cfg(REG_STEP_DISCOUNT, disc);
        write_cfg(REG_TREE_STEPS, steps);
    endtask

    task automatic test_reset_defaults();
        drain_results();
        send_item(make_word(PRICE_100, PRICE_90, 1'b0));
        send_item(make_word(PRICE_100, PRICE_90, 1'b1));
        send_item(make_word('0, WORD_ALL_ONES, 1'b1));
        send_item(make_word(WORD_ALL_ONES, '0, 1'b0));
    endtask

    task automatic test_zero_steps();
        drain_results();
        set_tree(ONE_Q30, ONE_Q30, ONE_Q30, ONE_Q31, '0);
        send_item(make_word(PRICE_100, PRICE_90, 1'b0));
        send_item(make_word(PRICE_100, PRICE_90, 1'b1));
        send_item(make_word(32'h1234_5678, 32'h1234_5678, 1'b0));
        send_item(make_word(WORD_ALL_ONES, '0, 1'b0));
    endtask

    task automatic test_leaf_saturation();
        drain_results();
        set_tree(32'(DOWN_ALL_ONES), WORD_ALL_ONES, ONE_Q30, ONE_Q31, 7);
        send_item(make_word(32'h0001_0000, '0, 1'b0));
        send_item(make_word(WORD_ALL_ONES, WORD_ALL_ONES, 1'b1));
        drain_results();
        set_tree('0, '0, ONE_Q30, ONE_Q31, 3);
        send_item(make_word(PRICE_100, PRICE_90, 1'b1));
    endtask

    task automatic test_prob_discount_clamp();
        drain_results();
        set_tree(32'h3E00_0000, 32'h4400_0000, WORD_ALL_ONES, WORD_ALL_ONES, 6);
        send_item(make_word(PRICE_100, PRICE_90, 1'b0));
        send_item(make_word(PRICE_100, PRICE_100, 1'b1));
        drain_results();
        write_cfg(REG_UP_PROB, '0);
        write_cfg(REG_STEP_DISCOUNT, '0);
        send_item(make_word(PRICE_100, PRICE_90, 1'b0));
        drain_results();
        write_cfg(REG_UP_PROB, ONE_Q31);
        write_cfg(REG_STEP_DISCOUNT, ONE_Q31);
        send_item(make_word(PRICE_90, PRICE_100, 1'b1));
    endtask

    task automatic test_unused_index();
        drain_results();
        for (int idx = int'(REG_TREE_STEPS) + 1; idx < 2 ** CFG_INDEX_W; idx++) begin
            write_cfg(CFG_INDEX_W'(idx), $urandom);
        end
        send_item(make_word(PRICE_100, PRICE_90, 1'b0));
        send_item(make_word(PRICE_90, PRICE_100, 1'b1));
    endtask

    task automatic test_max_steps();
        drain_results();
        set_tree(32'h3FE0_0000, 32'h4040_0000, ONE_Q30, 32'h7FFF_0000, 32'(STEPS_MAX));
        send_item(make_word(PRICE_100, PRICE_90, 1'b0));
    endtask

    task automatic test_random_phases();
        int unsigned       count;
        logic [WORD_W-1:0] spot;
        logic [WORD_W-1:0] strike;
        logic [WORD_W-1:0] steps;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            no_idle = (phase % 4 == 3);
            steps = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
            if ($urandom_range(0, 3) == 0) begin
                set_tree($urandom, $urandom, $urandom, $urandom, steps);
            end else begin
                set_tree($urandom_range(32'h3C00_0000, ONE_Q30),
                         $urandom_range(ONE_Q30, 32'h4800_0000),
                         $urandom_range(32'h3000_0000, 32'h5000_0000),
                         $urandom_range(32'h7F00_0000, ONE_Q31), steps);
            end
            count = $urandom_range(8, 12);
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    spot   = $urandom;
                    strike = $urandom;
                end else begin
                    spot   = $urandom_range(32'h0001_0000, 32'h0100_0000);
                    strike = spot - spot / 8 + $urandom_range(0, spot / 4);
                end
                send_item(make_word(spot, strike, 1'($urandom_range(0, 1))));
                if ($urandom_range(0, 14) == 0) begin
                    drain_results();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // result side stalls
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_result
        out_word_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (expected_prices.size() == 0) begin
                $display("%0t: unexpected word, actual price %h overflow %b",
                         $time, m_word.option_price, m_word.overflow);
                mismatch_count++;
            end else begin
                oldest = expected_prices.pop_front();
                if (oldest.option_price !== m_word.option_price) begin
                    $display("%0t: option_price expected %h actual %h",
                             $time, oldest.option_price, m_word.option_price);
                    mismatch_count++;
                end
                if (oldest.overflow !== m_word.overflow) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, oldest.overflow, m_word.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_zero_steps();
        test_leaf_saturation();
        test_prob_discount_clamp();
        test_unused_index();
        test_max_steps();
        test_random_phases();
        drain_results();
        repeat (END_SLACK) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
